### rtl/smac_pkg.sv
// Shared constants, codes and controller/datapath interface types of the shadow checker.
package smac_pkg;

  // Fixed field widths
  localparam int unsigned OP_W       = 2;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned SIZE_W     = 19;
  localparam int unsigned CODE_W     = 8;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  // One shadow byte per 2^SCALE_SHIFT heap bytes
  localparam int unsigned SCALE_SHIFT = 3;

  // Default heap window size in bytes
  localparam int unsigned HEAP_BYTES_DEF = 262144;

  // Operation codes
  localparam logic [OP_W-1:0] OP_CHECK    = 2'd0;
  localparam logic [OP_W-1:0] OP_POISON   = 2'd1;
  localparam logic [OP_W-1:0] OP_UNPOISON = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_EN  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE = 1'd1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;          // capture an input beat
    logic init;          // work out span bounds
    logic rd;            // read the shadow byte at the cursor
    logic wr_fill;       // write fill value at the cursor, step cursor
    logic wr_part;       // write partial-granule count after the span
    logic adv;           // step cursor
    logic push;          // load the output register
    logic res_poisoned;
    logic res_checked;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_check;
    logic is_fill;
    logic chk_ok;        // checking enabled and address inside heap
    logic in_heap;
    logic size_zero;
    logic span_empty;    // no shadow byte left after clipping
    logic fill_more;
    logic part_needed;
    logic rd_nz;         // shadow byte just read is nonzero
    logic at_last;
    logic hit;           // poisoned if not the last byte, or if its granule offset reaches the shadow value
    logic out_busy;      // output register cannot take a beat
  } status_t;

endpackage

### rtl/smac_datapath.sv
// Datapath of the shadow checker: item registers, span cursor, shadow memory, output register.
module smac_datapath #(
  parameter int unsigned HEAP_BYTES = smac_pkg::HEAP_BYTES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration
  input  logic                             cfg_we_i,
  input  logic [smac_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [smac_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  // input payload
  input  logic [smac_pkg::OP_W-1:0]        op_i,
  input  logic [smac_pkg::ADDR_W-1:0]      addr_i,
  input  logic [smac_pkg::SIZE_W-1:0]      size_i,
  input  logic [smac_pkg::CODE_W-1:0]      poison_code_i,
  // output channel
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             poisoned_o,
  output logic                             checked_o,
  // controller link
  input  smac_pkg::cmd_t                   cmd_i,
  output smac_pkg::status_t                status_o
);

  localparam int unsigned SH     = smac_pkg::SCALE_SHIFT;
  localparam int unsigned DEPTH  = HEAP_BYTES >> SH;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned OFF_W  = $clog2(HEAP_BYTES);
  localparam int unsigned SUM_W  = ((OFF_W > smac_pkg::SIZE_W) ? OFF_W : smac_pkg::SIZE_W) + 1;
  localparam int unsigned CUR_W  = OFF_W - SH + 1;
  localparam int unsigned END_W  = SUM_W - SH;

  localparam logic [smac_pkg::ADDR_W-1:0] HEAP_A   = smac_pkg::ADDR_W'(HEAP_BYTES);
  localparam logic [SUM_W-1:0]            HEAP_M1  = SUM_W'(HEAP_BYTES - 1);
  localparam logic [END_W-1:0]            DEPTH_E  = END_W'(DEPTH);
  localparam logic [CUR_W-1:0]            LAST_IDX = CUR_W'(DEPTH - 1);

  // Configuration registers
  logic                          check_en_q;
  logic [smac_pkg::ADDR_W-1:0]   heap_base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      check_en_q  <= 1'b0;
      heap_base_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        smac_pkg::CFG_CHECK_EN:  check_en_q  <= cfg_wdata_i[0];
        smac_pkg::CFG_HEAP_BASE: heap_base_q <= cfg_wdata_i[smac_pkg::ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // Heap offset of the incoming beat
  logic [smac_pkg::ADDR_W-1:0] off_full;
  assign off_full = addr_i - heap_base_q;

  // Item registers
  logic [smac_pkg::OP_W-1:0]   op_q;
  logic [OFF_W-1:0]            off_q;
  logic [smac_pkg::SIZE_W-1:0] size_q;
  logic [smac_pkg::CODE_W-1:0] code_q;
  logic                        inside_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= op_i;
      off_q    <= off_full[OFF_W-1:0];
      size_q   <= size_i;
      code_q   <= poison_code_i;
      inside_q <= (off_full < HEAP_A);
    end
  end

  // Span bounds: last byte clipped to the heap, end index of a fill
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] last_raw;
  assign sum      = SUM_W'(off_q) + SUM_W'(size_q);
  assign last_raw = sum - SUM_W'(1);

  logic [OFF_W-1:0] last_q;
  logic [END_W-1:0] end_q;
  logic [CUR_W-1:0] cur_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      last_q <= (last_raw > HEAP_M1) ? HEAP_M1[OFF_W-1:0] : last_raw[OFF_W-1:0];
      end_q  <= sum[SUM_W-1:SH];
      cur_q  <= CUR_W'(off_q >> SH);
    end else if (cmd_i.wr_fill || cmd_i.adv) begin
      cur_q  <= cur_q + CUR_W'(1);
    end
  end

  // Shadow memory, one write or one read a cycle
  logic [smac_pkg::CODE_W-1:0] mem [DEPTH];
  logic [smac_pkg::CODE_W-1:0] rdata_q;
  logic [smac_pkg::CODE_W-1:0] fill_val;
  assign fill_val = (op_q == smac_pkg::OP_POISON) ? code_q : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_fill) begin
      mem[cur_q[IDX_W-1:0]] <= fill_val;
    end else if (cmd_i.wr_part) begin
      mem[end_q[IDX_W-1:0]] <= smac_pkg::CODE_W'(size_q[SH-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rdata_q <= mem[cur_q[IDX_W-1:0]];
    end
  end

  // Derived span limits
  logic [CUR_W-1:0] lidx;
  logic [CUR_W-1:0] lidx_c;
  logic [END_W-1:0] stop;
  assign lidx   = CUR_W'(last_q >> SH);
  assign lidx_c = (lidx > LAST_IDX) ? LAST_IDX : lidx;
  assign stop   = (end_q > DEPTH_E) ? DEPTH_E : end_q;

  // Granule offset of the last byte against the shadow byte as signed
  logic signed [smac_pkg::CODE_W:0] gran_s;
  logic signed [smac_pkg::CODE_W:0] shadow_s;
  assign gran_s   = $signed({{(smac_pkg::CODE_W + 1 - SH){1'b0}}, last_q[SH-1:0]});
  assign shadow_s = $signed({rdata_q[smac_pkg::CODE_W-1], rdata_q});

  // Output register
  logic out_valid_q, poisoned_q, checked_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      poisoned_q <= cmd_i.res_poisoned;
      checked_q  <= cmd_i.res_checked;
    end
  end

  assign out_valid_o = out_valid_q;
  assign poisoned_o  = poisoned_q;
  assign checked_o   = checked_q;

  // Status to the controller
  always_comb begin
    status_o.is_check    = (op_q == smac_pkg::OP_CHECK);
    status_o.is_fill     = (op_q == smac_pkg::OP_POISON) || (op_q == smac_pkg::OP_UNPOISON);
    status_o.chk_ok      = check_en_q & inside_q;
    status_o.in_heap     = inside_q;
    status_o.size_zero   = (size_q == '0);
    status_o.span_empty  = (cur_q > lidx_c);
    status_o.fill_more   = (END_W'(cur_q) < stop);
    status_o.part_needed = (op_q == smac_pkg::OP_UNPOISON) && (size_q[SH-1:0] != '0)
                           && (end_q < DEPTH_E);
    status_o.rd_nz       = (rdata_q != '0);
    status_o.at_last     = (cur_q == lidx_c);
    status_o.hit         = (cur_q != lidx_c) || (gran_s >= shadow_s);
    status_o.out_busy    = out_valid_q & ~out_ready_i;
  end

endmodule

### rtl/smac_ctrl.sv
// Controller of the shadow checker: sequences setup, span walk and result hand-off.
module smac_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  smac_pkg::status_t  status_i,
  output smac_pkg::cmd_t     cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_DECIDE,
    ST_READ,
    ST_EVAL,
    ST_FILL,
    ST_RESULT
  } state_e;

  state_e state_q;
  logic   res_p_q, res_c_q;

  // State and held result bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      res_p_q <= 1'b0;
      res_c_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_INIT;
        end
        ST_INIT: state_q <= ST_DECIDE;
        ST_DECIDE: begin
          res_p_q <= 1'b0;
          res_c_q <= 1'b0;
          priority if (status_i.is_check) begin
            if (!status_i.chk_ok) begin
              state_q <= ST_RESULT;
            end else if (status_i.size_zero || status_i.span_empty) begin
              res_c_q <= 1'b1;
              state_q <= ST_RESULT;
            end else begin
              res_c_q <= 1'b1;
              state_q <= ST_READ;
            end
          end else if (status_i.is_fill && status_i.in_heap) begin
            state_q <= ST_FILL;
          end else begin
            state_q <= ST_RESULT;
          end
        end
        ST_READ: state_q <= ST_EVAL;
        ST_EVAL: begin
          priority if (status_i.rd_nz) begin
            res_p_q <= status_i.hit;
            state_q <= ST_RESULT;
          end else if (status_i.at_last) begin
            state_q <= ST_RESULT;
          end else begin
            state_q <= ST_READ;
          end
        end
        ST_FILL: begin
          if (!status_i.fill_more) state_q <= ST_RESULT;
        end
        ST_RESULT: begin
          if (!status_i.out_busy) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Commands
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o              = '0;
    cmd_o.res_poisoned = res_p_q;
    cmd_o.res_checked  = res_c_q;
    unique case (state_q)
      ST_IDLE:   cmd_o.load    = in_valid_i;
      ST_INIT:   cmd_o.init    = 1'b1;
      ST_READ:   cmd_o.rd      = 1'b1;
      ST_EVAL:   cmd_o.adv     = ~status_i.rd_nz & ~status_i.at_last;
      ST_FILL: begin
        cmd_o.wr_fill = status_i.fill_more;
        cmd_o.wr_part = ~status_i.fill_more & status_i.part_needed;
      end
      ST_RESULT: cmd_o.push    = ~status_i.out_busy;
      default: ;
    endcase
  end

endmodule

### rtl/shadow_memory_access_checker.sv
// Top level of the shadow memory access checker.
// The block keeps one shadow byte per 8 heap bytes and handles one item at a time. A check
// goes through the init and decide states and then walks the shadow bytes up to the first
// nonzero one (one or two for usual accesses); each byte costs a registered read of the
// single shadow memory port and an evaluate state. A poison or unpoison writes its shadow
// bytes at one write a cycle through the same port; the partial-granule byte of an unpoison
// goes out in the closing cycle of the walk at no extra cost. Items outside the heap,
// skipped or zero-size checks and unused op codes go from the decide state straight to
// the result. The result sits in an output register, so the next beat is taken while it
// waits; a further result waits for that register to drain. The shadow store is not
// cleared after reset: software writes it, normally by poisoning the whole heap, before
// anything is checked.
module shadow_memory_access_checker #(
  parameter int unsigned HEAP_BYTES = smac_pkg::HEAP_BYTES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [smac_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [smac_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [smac_pkg::OP_W-1:0]       op_i,
  input  logic [smac_pkg::ADDR_W-1:0]     addr_i,
  input  logic [smac_pkg::SIZE_W-1:0]     size_i,
  input  logic [smac_pkg::CODE_W-1:0]     poison_code_i,
  // output channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            poisoned_o,
  output logic                            checked_o
);

  smac_pkg::cmd_t    cmd;
  smac_pkg::status_t status;

  // Sequencer
  smac_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Registers, shadow memory and output beat
  smac_datapath #(
    .HEAP_BYTES (HEAP_BYTES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .op_i          (op_i),
    .addr_i        (addr_i),
    .size_i        (size_i),
    .poison_code_i (poison_code_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .poisoned_o    (poisoned_o),
    .checked_o     (checked_o),
    .cmd_i         (cmd),
    .status_o      (status)
  );

endmodule

### tb/shadow_memory_access_checker_test.sv
// Self-checking testbench for the shadow memory access checker: directed table plus random traffic.
module shadow_memory_access_checker_test;

  localparam int unsigned HEAP_BYTES      = smac_pkg::HEAP_BYTES_DEF;
  localparam int unsigned SHADOW_DEPTH    = HEAP_BYTES >> smac_pkg::SCALE_SHIFT;
  localparam logic [smac_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int          N_PHASES        = 6;
  localparam int          ITEMS_PER_PHASE = 180;
  localparam int          BIG_ITEM_AT     = 120;
  localparam int          SETTLE_CYCLES   = 8;
  localparam longint      RUN_LIMIT       = 10_000_000;

  // One result beat as the checker reports it
  typedef struct packed {
    logic poisoned;
    logic checked;
  } verdict_t;

  // Directed stimulus: item beats and register writes in one table
  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e                       kind;
    logic [smac_pkg::CFG_IDX_W-1:0]  reg_idx;
    logic [smac_pkg::OP_W-1:0]       op;
    logic [smac_pkg::ADDR_W-1:0]     addr;     // register value on write rows
    logic [smac_pkg::SIZE_W-1:0]     size;
    logic [smac_pkg::CODE_W-1:0]     code;
    logic                            typed;    // expected result given below
    logic                            t_poisoned;
    logic                            t_checked;
  } stim_row_t;

  localparam int N_DIRECTED = 32;

  stim_row_t directed_rows [N_DIRECTED] = '{
    // fill the whole heap first, so every later read sees written shadow
    '{ROW_ITEM, smac_pkg::CFG_CHECK_EN, smac_pkg::OP_POISON, 32'h0000_0000, 19'd262144,
      8'hFB, 1'b1, 1'b0, 1'b0},
    '{ROW_ITEM, smac_pkg::CFG_CHECK_EN, smac_pkg::OP_CHECK, 32'h0000_0000, 19'd8,
      8'h00, 1'b1, 1'b0, 1'b0},
    '{ROW_CFG, smac_pkg::CFG_CHECK_EN, smac_pkg::OP_CHECK, 32'h0000_0001, 19'd0,
      8'h00, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, smac_pkg::CFG_CHECK_EN, smac_pkg::OP_CHECK, 32'h0000_0000, 19'd1,
      8'h00, 1'b1, 1'b1, 1'b1},
    // partial granule: 13 bytes leaves 5 valid in the second granule
    '{ROW_ITEM, smac_pkg::CFG_CHECK_EN, smac_pkg::OP_UNPOISON, 32'h0000_0000, 19'd13,
      8'h00, 1'b1, 1'b0, 1'b0},
    '{ROW_ITEM, smac_pkg::CFG_CHECK_EN, smac_pkg::OP_CHECK, 32'h0000_0000, 19'd13,
      8'h00, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, smac_pkg::CFG_CHECK_EN, smac_pkg::OP_CHECK, 32'h0000_0000, 19'd14,
      8'h00, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, smac_pkg::CFG_CHECK_EN, smac_pkg::OP_CHECK, 32'h0000_0005, 19'd0,
      8'h00, 1'b1, 1'b0, 1'b1},
    '{ROW_ITEM, smac_pkg::CFG_CHECK_EN, OP_UNUSED, 32'h0000_0000, 19'd8,
      8'hAA, 1'b1, 1'b0, 1'b0},
    '{ROW_ITEM, smac_pkg::CFG_CHECK_EN, smac_pkg::OP_CHECK, 32'h0004_0000, 19'd8,
      8'h00, 1'b1, 1'b0, 1'b0},
    '{ROW_ITEM, smac_pkg::CFG_CHECK_EN, smac_pkg::OP_CHECK, 32'hFFFF_FFFF, 19'h7FFFF,
      8'hFF, 1'b1, 1'b0, 1'b0},
    // accesses and ranges running past the heap end
    '{ROW_ITEM, smac_pkg::CFG_CHECK_EN, smac_pkg::OP_CHECK, 32'h0003_FFFC, 19'd100,
      8'h00, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, smac_pkg::CFG_CHECK_EN, smac_pkg::OP_UNPOISON, 32'h0003_FFF8, 19'd20,
      8'h00, 1'b1, 1'b0, 1'b0},
    '{ROW_ITEM, smac_pkg::CFG_CHECK_EN, smac_pkg::OP_CHECK, 32'h0003_FFF8, 19'd8,
      8'h00, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, smac_pkg::CFG_CHECK_EN, smac_pkg::OP_CHECK, 32'h0003_FFF8, 19'h7FFFF,
      8'h00, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, smac_pkg::CFG_CHECK_EN, smac_pkg::OP_POISON, 32'h0000_0064, 19'd0,
      8'h55, 1'b1, 1'b0, 1'b0},
    '{ROW_ITEM, smac_pkg::CFG_CHECK_EN, smac_pkg::OP_POISON, 32'h0000_0040, 19'd16,
      8'hFF, 1'b1, 1'b0, 1'b0},
    '{ROW_ITEM, smac_pkg::CFG_CHECK_EN, smac_pkg::OP_CHECK, 32'h0000_0040, 19'd1,
      8'h00, 1'b0, 1'b0, 1'b0},
    // largest positive code reads as a fully valid granule
    '{ROW_ITEM, smac_pkg::CFG_CHECK_EN, smac_pkg::OP_POISON, 32'h0000_0050, 19'd8,
      8'h7F, 1'b1, 1'b0, 1'b0},
    '{ROW_ITEM, smac_pkg::CFG_CHECK_EN, smac_pkg::OP_CHECK, 32'h0000_0050, 19'd8,
      8'h00, 1'b0, 1'b0, 1'b0},
    // heap window wrapping past the top of the address space
    '{ROW_CFG, smac_pkg::CFG_HEAP_BASE, smac_pkg::OP_CHECK, 32'hFFFF_FFF8, 19'd0,
      8'h00, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, smac_pkg::CFG_CHECK_EN, smac_pkg::OP_CHECK, 32'hFFFF_FFF8, 19'd8,
      8'h00, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, smac_pkg::CFG_CHECK_EN, smac_pkg::OP_CHECK, 32'h0000_0004, 19'd4,
      8'h00, 1'b0, 1'b0, 1'b0},
    // unaligned base
    '{ROW_CFG, smac_pkg::CFG_HEAP_BASE, smac_pkg::OP_CHECK, 32'h0000_0003, 19'd0,
      8'h00, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, smac_pkg::CFG_CHECK_EN, smac_pkg::OP_CHECK, 32'h0000_0002, 19'd8,
      8'h00, 1'b1, 1'b0, 1'b0},
    '{ROW_ITEM, smac_pkg::CFG_CHECK_EN, smac_pkg::OP_CHECK, 32'h0000_0003, 19'h7FFFF,
      8'h00, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG, smac_pkg::CFG_HEAP_BASE, smac_pkg::OP_CHECK, 32'hFFFF_FFFF, 19'd0,
      8'h00, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, smac_pkg::CFG_CHECK_EN, smac_pkg::OP_UNPOISON, 32'hFFFF_FFFF, 19'd3,
      8'h00, 1'b1, 1'b0, 1'b0},
    '{ROW_ITEM, smac_pkg::CFG_CHECK_EN, smac_pkg::OP_CHECK, 32'h0000_0001, 19'd1,
      8'h00, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, smac_pkg::CFG_CHECK_EN, smac_pkg::OP_CHECK, 32'h0000_0002, 19'd1,
      8'h00, 1'b0, 1'b0, 1'b0},
    // checking switched off again
    '{ROW_CFG, smac_pkg::CFG_CHECK_EN, smac_pkg::OP_CHECK, 32'h0000_0000, 19'd0,
      8'h00, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, smac_pkg::CFG_CHECK_EN, smac_pkg::OP_CHECK, 32'h0000_0000, 19'd8,
      8'h00, 1'b1, 1'b0, 1'b0}
  };

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [smac_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [smac_pkg::CFG_DATA_W-1:0] cfg_wdata_i;
  logic                            in_valid_i;
  logic                            in_ready_o;
  logic [smac_pkg::OP_W-1:0]       op_i;
  logic [smac_pkg::ADDR_W-1:0]     addr_i;
  logic [smac_pkg::SIZE_W-1:0]     size_i;
  logic [smac_pkg::CODE_W-1:0]     poison_code_i;
  logic                            out_valid_o;
  logic                            out_ready_i;
  logic                            poisoned_o;
  logic                            checked_o;

  // Mirror of the block's state and registers
  logic [7:0]            shadow_mirror [SHADOW_DEPTH];
  logic                  check_en_q;
  logic [31:0]           heap_base_q;

  verdict_t              verdict_queue [$];
  bit                    gaps_on;
  int unsigned           alloc_off;
  int unsigned           alloc_len;
  int                    mismatch_count;
  int                    items_sent;
  int                    reg_writes;
  int                    checks_done;
  int                    hits_seen;

  shadow_memory_access_checker #(
    .HEAP_BYTES (HEAP_BYTES)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .addr_i        (addr_i),
    .size_i        (size_i),
    .poison_code_i (poison_code_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .poisoned_o    (poisoned_o),
    .checked_o     (checked_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop
  initial begin
    #(RUN_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  // Works out the verdict of one beat and applies its writes to the shadow mirror
  task automatic predict_shadow_access(input logic [smac_pkg::OP_W-1:0] op,
                                       input logic [smac_pkg::ADDR_W-1:0] addr,
                                       input logic [smac_pkg::SIZE_W-1:0] size,
                                       input logic [smac_pkg::CODE_W-1:0] code,
                                       output verdict_t v);
    logic [31:0]     off;
    longint unsigned last_b;
    longint unsigned last_idx;
    longint unsigned end_idx;
    longint unsigned i;
    int              sval;
    bit              found;
    off = addr - heap_base_q;
    v   = '0;
    if (off < HEAP_BYTES) begin
      if (op == smac_pkg::OP_CHECK && check_en_q) begin
        v.checked = 1'b1;
        if (size != '0) begin
          last_b = off;
          last_b = last_b + size - 1;
          if (last_b >= HEAP_BYTES) last_b = HEAP_BYTES - 1;
          last_idx = last_b >> smac_pkg::SCALE_SHIFT;
          found    = 1'b0;
          // first nonzero shadow byte decides
          for (i = off >> smac_pkg::SCALE_SHIFT; i <= last_idx && !found; i++) begin
            if (shadow_mirror[i] != 8'h00) begin
              found = 1'b1;
              sval  = $signed(shadow_mirror[i]);
              if (i != last_idx) v.poisoned = 1'b1;
              else v.poisoned = (int'(last_b[2:0]) >= sval);
            end
          end
        end
      end else if (op == smac_pkg::OP_POISON || op == smac_pkg::OP_UNPOISON) begin
        end_idx = off;
        end_idx = (end_idx + size) >> smac_pkg::SCALE_SHIFT;
        for (i = off >> smac_pkg::SCALE_SHIFT; i < end_idx && i < SHADOW_DEPTH; i++)
          shadow_mirror[i] = (op == smac_pkg::OP_POISON) ? code : 8'h00;
        if (op == smac_pkg::OP_UNPOISON && size[2:0] != 3'd0 && end_idx < SHADOW_DEPTH)
          shadow_mirror[end_idx] = {5'd0, size[2:0]};
      end
    end
  endtask

  // Drives one beat, waits for acceptance and queues its verdict
  task automatic send_item(input logic [smac_pkg::OP_W-1:0] op,
                           input logic [smac_pkg::ADDR_W-1:0] addr,
                           input logic [smac_pkg::SIZE_W-1:0] size,
                           input logic [smac_pkg::CODE_W-1:0] code,
                           input bit typed, input verdict_t typed_v);
    verdict_t v;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    op_i          <= op;
    addr_i        <= addr;
    size_i        <= size;
    poison_code_i <= code;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_shadow_access(op, addr, size, code, v);
    if (typed) v = typed_v;
    verdict_queue.push_back(v);
    items_sent++;
    if (v.checked) checks_done++;
    if (v.poisoned) hits_seen++;
    @(negedge clk_i);
  endtask

  // Holds the sender off until every queued verdict has come back
  task automatic drain_results(input bit settle);
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (verdict_queue.size() != 0);
    if (settle) repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Register write, block idle
  task automatic write_reg(input logic [smac_pkg::CFG_IDX_W-1:0] idx,
                           input logic [smac_pkg::CFG_DATA_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == smac_pkg::CFG_CHECK_EN) check_en_q = value[0];
    else heap_base_q = value;
    reg_writes++;
    @(negedge clk_i);
  endtask

  // Random beat: mostly allocate / access / free traffic, some noise
  task automatic next_random_item(input bit big, output logic [smac_pkg::OP_W-1:0] op,
                                  output logic [smac_pkg::ADDR_W-1:0] addr,
                                  output logic [smac_pkg::SIZE_W-1:0] size,
                                  output logic [smac_pkg::CODE_W-1:0] code);
    int unsigned pick;
    int          delta;
    pick = $urandom_range(0, 99);
    code = smac_pkg::CODE_W'($urandom_range(0, 255));
    op   = smac_pkg::OP_CHECK;
    if (big) begin
      // long walk over at least half of the store
      op   = smac_pkg::OP_W'($urandom_range(0, 2));
      addr = heap_base_q + $urandom_range(0, 63) * 8;
      size = smac_pkg::SIZE_W'($urandom_range(131072, 524287));
    end else if (pick < 8) begin
      op   = smac_pkg::OP_W'($urandom_range(0, 3));
      addr = $urandom;
      size = smac_pkg::SIZE_W'($urandom_range(0, 64));
    end else if (pick < 22) begin
      alloc_off = $urandom_range(0, SHADOW_DEPTH - 64) * 8;
      alloc_len = $urandom_range(1, 256);
      op   = smac_pkg::OP_UNPOISON;
      addr = heap_base_q + alloc_off;
      size = smac_pkg::SIZE_W'(alloc_len);
    end else if (pick < 30) begin
      op   = smac_pkg::OP_POISON;
      addr = heap_base_q + alloc_off;
      size = smac_pkg::SIZE_W'((alloc_len + 7) & ~32'd7);
    end else if (pick < 40) begin
      addr = heap_base_q + $urandom_range(0, HEAP_BYTES - 1);
      size = smac_pkg::SIZE_W'($urandom_range(0, 64));
    end else begin
      // access around the live allocation, edges included
      delta = int'($urandom_range(0, alloc_len + 16)) - 8;
      addr  = heap_base_q + alloc_off + 32'(delta);
      case ($urandom_range(0, 5))
        0:       size = 19'd1;
        1:       size = 19'd2;
        2:       size = 19'd4;
        3:       size = 19'd8;
        4:       size = 19'd16;
        default: size = smac_pkg::SIZE_W'($urandom_range(0, 24));
      endcase
    end
  endtask

  // Output side: random stall bursts
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // Result checking against the oldest expectation
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (verdict_queue.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result beat, poisoned %0b checked %0b",
                 $time, poisoned_o, checked_o);
      end else begin
        want = verdict_queue.pop_front();
        if (poisoned_o !== want.poisoned) begin
          mismatch_count++;
          $display("%0t: poisoned expected %0b actual %0b", $time, want.poisoned, poisoned_o);
        end
        if (checked_o !== want.checked) begin
          mismatch_count++;
          $display("%0t: checked expected %0b actual %0b", $time, want.checked, checked_o);
        end
      end
    end
  end

  // Stimulus
  initial begin
    stim_row_t                   row;
    verdict_t                    typed_v;
    logic [smac_pkg::OP_W-1:0]   op;
    logic [smac_pkg::ADDR_W-1:0] addr;
    logic [smac_pkg::SIZE_W-1:0] size;
    logic [smac_pkg::CODE_W-1:0] code;
    logic [31:0]                 base;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    op_i           = smac_pkg::OP_CHECK;
    addr_i         = '0;
    size_i         = '0;
    poison_code_i  = '0;
    check_en_q     = 1'b0;
    heap_base_q    = '0;
    gaps_on        = 1'b0;
    alloc_off      = 0;
    alloc_len      = 16;
    mismatch_count = 0;
    items_sent     = 0;
    reg_writes     = 0;
    checks_done    = 0;
    hits_seen      = 0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table
    gaps_on = 1'b1;
    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      if (row.kind == ROW_CFG) begin
        drain_results(1'b1);
        write_reg(row.reg_idx, row.addr);
      end else begin
        typed_v = '{poisoned: row.t_poisoned, checked: row.t_checked};
        send_item(row.op, row.addr, row.size, row.code, row.typed, typed_v);
      end
    end

    // random phases, each with its own register setting
    for (int p = 0; p < N_PHASES; p++) begin
      drain_results(1'b1);
      case (p)
        0:       base = 32'h0000_0000;
        1:       base = 32'hFFFF_FFFF;
        3:       base = $urandom & ~32'd7;
        default: base = $urandom;
      endcase
      write_reg(smac_pkg::CFG_CHECK_EN, {31'd0, p != 2});
      write_reg(smac_pkg::CFG_HEAP_BASE, base);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        gaps_on = (p != N_PHASES - 1) && ((n / 45) % 2 == 0);
        if (n == ITEMS_PER_PHASE / 2) drain_results(1'b0);
        next_random_item(n == BIG_ITEM_AT, op, addr, size, code);
        send_item(op, addr, size, code, 1'b0, '0);
      end
    end

    drain_results(1'b1);
    $display("Run covered %0d beats under %0d register writes: %0d checks ran, %0d poisoned.",
             items_sent, reg_writes, checks_done, hits_seen);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### files.f
rtl/smac_pkg.sv
rtl/smac_datapath.sv
rtl/smac_ctrl.sv
rtl/shadow_memory_access_checker.sv
tb/shadow_memory_access_checker_test.sv
